// File: rtl/sha512t_pkg.sv
// SHA-512/256 engine package: state enum, initial hash values, round constants.
// Used by sha512t_round and sha512_256_hash_engine_unit.
package sha512t_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        logic [63:0] v;
        case (i)
            3'd0: v = 64'h22312194FC2BF72C;
            3'd1: v = 64'h9F555FA3C84C64C2;
            3'd2: v = 64'h2393B86B6F53B151;
            3'd3: v = 64'h963877195940EABD;
            3'd4: v = 64'h96283EE2A88EFFE3;
            3'd5: v = 64'hBE5E1E2553863992;
            3'd6: v = 64'h2B0199FC2C85B8AA;
            default: v = 64'h0EB72DDC81C52CA2;
        endcase
        return v;
    endfunction

    localparam logic [63:0] K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    typedef logic [7:0][63:0] t_vars;

endpackage

// File: rtl/sha512t_if.sv
// Valid/ready channel interfaces for the SHA-512/256 engine.
// Standalone; no package dependency.
interface sha512t_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  bytes_valid;
    logic        last_item;
    modport source (output valid, message_word, bytes_valid, last_item, input ready);
    modport sink   (input valid, message_word, bytes_valid, last_item, output ready);
endinterface

interface sha512t_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/sha512t_round.sv
// One SHA-512 compression round: combinational round function on working vars.
// Depends on sha512t_pkg.
module sha512t_round (
    input  sha512t_pkg::t_vars i_v,
    input  logic [63:0]        i_k,
    input  logic [63:0]        i_w,
    output sha512t_pkg::t_vars o_v
);
    logic [63:0] s1, ch, s0, mj, t1, t2;

    always_comb begin
        s1 = {i_v[4][13:0], i_v[4][63:14]} ^ {i_v[4][17:0], i_v[4][63:18]}
           ^ {i_v[4][40:0], i_v[4][63:41]};
        ch = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        s0 = {i_v[0][27:0], i_v[0][63:28]} ^ {i_v[0][33:0], i_v[0][63:34]}
           ^ {i_v[0][38:0], i_v[0][63:39]};
        mj = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        t1 = i_v[7] + s1 + ch + i_k + i_w;
        t2 = s0 + mj;
        o_v[7] = i_v[6];
        o_v[6] = i_v[5];
        o_v[5] = i_v[4];
        o_v[4] = i_v[3] + t1;
        o_v[3] = i_v[2];
        o_v[2] = i_v[1];
        o_v[1] = i_v[0];
        o_v[0] = t1 + t2;
    end
endmodule

// File: rtl/sha512_256_hash_engine_unit.sv
// SHA-512/256 engine top level: buffer, bit count, padding sequencer, round loop.
// Depends on sha512t_pkg, sha512t_if, sha512t_round.
//
// channel  dir  payload                                  transfer
// in       in   message_word, bytes_valid, last_item    valid & ready
// out      out  digest_word, word_index, last_word      valid & ready
//
// A word that does not fill the block is only stored; one filling it starts the 80
// rounds and then a fold step (shared round unit, one round per cycle).
// A last item adds one or two padding passes, each writing the pad words and then
// running the block, after the rounds of a block it fills; then 4 output transfers.
// Reset is synchronous, active low; input is not ready until output drains.
module sha512_256_hash_engine_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sha512t_in_if.sink           i_in,
    sha512t_out_if.source        o_out
);
    sha512t_pkg::t_state r_state, n_state;
    logic [63:0] r_buf [16];
    logic [63:0] r_sched [16];
    sha512t_pkg::t_vars r_h, r_v, w_vnext;
    logic [3:0]  r_fill;
    logic [63:0] r_cnt_lo, r_cnt_hi;
    logic [6:0]  r_round;
    logic        r_last, r_second, r_mark;
    logic [3:0]  r_padi;
    logic [1:0]  r_oidx;
    logic [63:0] w_w, w_a, w_b, w_s0, w_s1;
    logic [3:0]  w_nb;
    logic [63:0] w_mask;
    logic [6:0]  w_add;
    logic [64:0] w_sum;
    logic        w_acc, w_full, w_fits;

    assign w_acc = i_in.valid & i_in.ready;
    assign w_nb  = (!i_in.last_item || i_in.bytes_valid > 4'd8) ? 4'd8 : i_in.bytes_valid;
    assign w_add = {w_nb, 3'b000};
    assign w_sum = {1'b0, r_cnt_lo} + {58'd0, w_add};
    assign w_full = (w_nb == 4'd8);
    assign w_mask = (w_nb == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {w_nb[2:0], 3'b000});
    // length fits when data plus marker end at or before word 13
    assign w_fits = ({1'b0, r_fill} + {4'd0, !r_mark}) <= 5'd14;

    assign w_a  = r_sched[r_round[3:0] + 4'd1];
    assign w_b  = r_sched[r_round[3:0] + 4'd14];
    assign w_s0 = {w_a[0], w_a[63:1]} ^ {w_a[7:0], w_a[63:8]} ^ (w_a >> 7);
    assign w_s1 = {w_b[18:0], w_b[63:19]} ^ {w_b[60:0], w_b[63:61]} ^ (w_b >> 6);
    assign w_w  = (r_round < 7'd16) ? r_buf[r_round[3:0]]
                : r_sched[r_round[3:0]] + w_s0 + r_sched[r_round[3:0] + 4'd9] + w_s1;

    sha512t_round u_round (
        .i_v (r_v),
        .i_k (sha512t_pkg::K[r_round]),
        .i_w (w_w),
        .o_v (w_vnext)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            sha512t_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (r_fill == 4'd15)          n_state = sha512t_pkg::ST_COMP;
                    else if (i_in.last_item)      n_state = sha512t_pkg::ST_PAD;
                end
            end
            sha512t_pkg::ST_COMP: if (r_round == 7'd79) n_state = sha512t_pkg::ST_FOLD;
            sha512t_pkg::ST_FOLD: begin
                if (!r_last)           n_state = sha512t_pkg::ST_IDLE;
                else if (r_second)     n_state = sha512t_pkg::ST_OUT;
                else                   n_state = sha512t_pkg::ST_PAD;
            end
            sha512t_pkg::ST_PAD: if (r_padi == 4'd15) n_state = sha512t_pkg::ST_COMP;
            sha512t_pkg::ST_OUT: if (o_out.ready && r_oidx == 2'd3) n_state = sha512t_pkg::ST_IDLE;
            default: n_state = sha512t_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready        = (r_state == sha512t_pkg::ST_IDLE);
        o_out.valid       = (r_state == sha512t_pkg::ST_OUT);
        o_out.digest_word = r_h[r_oidx];
        o_out.word_index  = r_oidx;
        o_out.last_word   = (r_oidx == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha512t_pkg::ST_IDLE;
            r_fill   <= '0;
            r_cnt_lo <= '0;
            r_cnt_hi <= '0;
            r_round  <= '0;
            r_last   <= 1'b0;
            r_second <= 1'b0;
            r_mark   <= 1'b0;
            r_padi   <= '0;
            r_oidx   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha512t_pkg::init_hash(3'(i));
        end else begin
            r_state <= n_state;
            case (r_state)
                sha512t_pkg::ST_IDLE: begin
                    if (w_acc) begin
                        r_cnt_lo <= w_sum[63:0];
                        r_cnt_hi <= r_cnt_hi + {63'd0, w_sum[64]};
                        r_last   <= i_in.last_item;
                        r_second <= 1'b0;
                        r_mark   <= !w_full;
                        r_padi   <= '0;
                        r_round  <= '0;
                        r_v      <= r_h;
                        r_fill   <= r_fill + 4'd1;
                        if (w_full) begin
                            r_buf[r_fill] <= i_in.message_word;
                        end else begin
                            r_buf[r_fill] <= (i_in.message_word & w_mask)
                                           | (sha512t_pkg::PAD_WORD >> {w_nb[2:0], 3'b000});
                        end
                    end
                end
                sha512t_pkg::ST_COMP: begin
                    r_sched[r_round[3:0]] <= w_w;
                    r_v     <= w_vnext;
                    r_round <= r_round + 7'd1;
                end
                sha512t_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_fill  <= '0;
                    r_padi  <= '0;
                end
                sha512t_pkg::ST_PAD: begin
                    // r_mark set: 0x80 already placed; else first free word gets it
                    if (r_padi >= r_fill) begin
                        if (r_padi == r_fill && !r_mark)
                            r_buf[r_padi] <= sha512t_pkg::PAD_WORD;
                        else if (w_fits && r_padi == 4'd14)
                            r_buf[r_padi] <= r_cnt_hi;
                        else if (w_fits && r_padi == 4'd15)
                            r_buf[r_padi] <= r_cnt_lo;
                        else
                            r_buf[r_padi] <= '0;
                    end
                    if (r_padi == 4'd15) begin
                        r_round  <= '0;
                        r_v      <= r_h;
                        r_second <= w_fits;
                        r_mark   <= 1'b1;
                    end
                    r_padi <= r_padi + 4'd1;
                end
                sha512t_pkg::ST_OUT: begin
                    if (o_out.ready) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= sha512t_pkg::init_hash(3'(i));
                            r_fill   <= '0;
                            r_cnt_lo <= '0;
                            r_cnt_hi <= '0;
                            r_last   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sha512t_pkg::ST_COMP |-> r_round < 7'd80) else $error("round overrun");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != sha512t_pkg::ST_IDLE |-> !i_in.ready) else $error("ready while busy");
    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && r_oidx == 2'd3) |=> r_state == sha512t_pkg::ST_IDLE)
        else $error("digest end");
`endif
endmodule
